// ===== rtl/core/dept_pkg.sv =====
// ----------------------------------------------------------------------------
// dept_pkg: shared definitions for the directional extreme point tracker
// Field widths, command codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package dept_pkg;

    // Fixed field widths
    localparam int SLOT_W = 7;
    localparam int DIR_W  = 16;
    localparam int NDIR_W = 8;

    // Defaults for the top-level parameters
    localparam int MAX_DIRECTIONS_DEF = 128;
    localparam int COORD_BITS_DEF     = 16;

    // Reset value of the direction count register
    localparam logic [NDIR_W-1:0] NUM_DIR_RESET = 8'd128;

    // Item commands; the remaining code is unknown and yields a zero result
    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_LOAD = 2'd1,
        CMD_READ = 2'd2
    } cmd_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // latch the input transfer
        logic clear_step; // clear one score entry during the reset pass
        logic issue;      // read the slot at the sweep address and advance
        logic mem_op;     // load write or read lookup of the latched slot
        logic finish;     // load the result register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic sweep_last; // sweep address is the last slot in use
        logic clear_top;  // sweep address is the last slot of the table
        logic count_zero; // no slot in use
        logic pipe_busy;  // sweep pipeline still holds slots
    } dp_status_t;

endpackage

// ===== rtl/core/dept_ctrl.sv =====
// ----------------------------------------------------------------------------
// dept_ctrl: sequencing controller
// Runs the clearing pass after reset, then takes one item at a time and
// steps the datapath through the load, read or sweep of that item.
// ----------------------------------------------------------------------------
module dept_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [1:0]            in_cmd,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output dept_pkg::dp_cmd_t     cmd,
    input  dept_pkg::dp_status_t  status
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_SWEEP,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic   m_tvalid_reg;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd            = '0;
        cmd.accept     = s_tvalid && (state_reg == ST_IDLE);
        cmd.clear_step = (state_reg == ST_CLEAR);
        cmd.issue      = (state_reg == ST_SWEEP);
        cmd.mem_op     = (state_reg == ST_LOOKUP);
        cmd.finish     = (state_reg == ST_DONE) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            m_tvalid_reg <= 1'b0;
        end else begin
            // hold the result until the transfer completes
            if (cmd.finish) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR: begin
                    if (status.clear_top) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (cmd.accept) begin
                        unique case (in_cmd)
                            dept_pkg::CMD_ADD: begin
                                state_reg <= status.count_zero ? ST_DONE : ST_SWEEP;
                            end
                            dept_pkg::CMD_LOAD,
                            dept_pkg::CMD_READ: state_reg <= ST_LOOKUP;
                            default:            state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_LOOKUP: state_reg <= ST_DONE;
                ST_SWEEP: begin
                    if (status.sweep_last) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!status.pipe_busy) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/dept_datapath.sv =====
// ----------------------------------------------------------------------------
// dept_datapath: slot tables, dot product pipeline and result register
// Direction, score and point memories with registered reads; a four-stage
// sweep pipeline (read, multiply, sum, compare and write back).
// ----------------------------------------------------------------------------
module dept_datapath #(
    parameter int MAX_DIRECTIONS = dept_pkg::MAX_DIRECTIONS_DEF,
    parameter int COORD_BITS     = dept_pkg::COORD_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  dept_pkg::dp_cmd_t                 cmd,
    output dept_pkg::dp_status_t              status,
    input  logic [1:0]                        in_cmd,
    input  logic [dept_pkg::SLOT_W-1:0]       in_slot,
    input  logic [3*dept_pkg::DIR_W-1:0]      in_dir,
    input  logic [3*COORD_BITS-1:0]           in_point,
    input  logic                              cfg_we,
    input  logic [dept_pkg::NDIR_W-1:0]       cfg_wdata,
    output logic                              res_changed,
    output logic                              res_entry_valid,
    output logic [3*COORD_BITS-1:0]           res_point
);

    localparam int DW      = dept_pkg::DIR_W;
    localparam int AW      = $clog2(MAX_DIRECTIONS);
    localparam int CW      = $clog2(MAX_DIRECTIONS + 1);
    localparam int PROD_W  = DW + COORD_BITS;
    localparam int SCORE_W = PROD_W + 2;
    localparam int PT_W    = 3 * COORD_BITS;

    // Memories; score entries carry the slot's valid flag in the top bit
    logic [3*DW-1:0]  dir_mem   [MAX_DIRECTIONS];
    logic [SCORE_W:0] score_mem [MAX_DIRECTIONS];
    logic [PT_W-1:0]  point_mem [MAX_DIRECTIONS];

    logic [dept_pkg::NDIR_W-1:0] num_dir_reg;
    dept_pkg::cmd_t              cmd_reg;
    logic [AW-1:0]               slot_addr_reg;
    logic                        slot_ok_reg;
    logic [3*DW-1:0]             dir_reg;
    logic [PT_W-1:0]             point_reg;
    logic [AW-1:0]               last_reg;
    logic [AW-1:0]               addr_reg;
    logic                        changed_reg;

    logic [3*DW-1:0]  dir_rd_reg;
    logic [SCORE_W:0] score_rd_reg;
    logic [PT_W-1:0]  point_rd_reg;

    logic                     v1_reg, v2_reg, v3_reg;
    logic [AW-1:0]            addr1_reg, addr2_reg, addr3_reg;
    logic signed [PROD_W-1:0] prod_reg [3];
    logic signed [PROD_W-1:0] prod_next [3];
    logic [SCORE_W:0]         old2_reg, old3_reg;
    logic signed [SCORE_W-1:0] sum3_reg;
    logic signed [SCORE_W-1:0] sum_next;

    logic [CW-1:0]    eff_count;
    logic             in_slot_ok;
    logic             better;
    logic             read_hit;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             sc_we;
    logic [AW-1:0]    sc_waddr;
    logic [SCORE_W:0] sc_wdata;
    logic             pt_we;
    logic             dir_we;

    // Slots in use, saturated at the table depth
    assign eff_count  = (32'(num_dir_reg) > MAX_DIRECTIONS) ? CW'(MAX_DIRECTIONS)
                                                            : CW'(num_dir_reg);
    assign in_slot_ok = 32'(in_slot) < MAX_DIRECTIONS;

    assign status.sweep_last = (addr_reg == last_reg);
    assign status.clear_top  = (addr_reg == AW'(MAX_DIRECTIONS - 1));
    assign status.count_zero = (num_dir_reg == '0);
    assign status.pipe_busy  = v1_reg || v2_reg || v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_dir_reg <= dept_pkg::NUM_DIR_RESET;
        end else if (cfg_we) begin
            num_dir_reg <= cfg_wdata;
        end
    end

    // Item latch and sweep address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg    <= '0;
            changed_reg <= 1'b0;
        end else begin
            if (cmd.accept) begin
                addr_reg    <= '0;
                changed_reg <= 1'b0;
            end else if (cmd.issue || cmd.clear_step) begin
                addr_reg <= addr_reg + AW'(1);
            end
            if (v3_reg && better) begin
                changed_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            cmd_reg       <= dept_pkg::cmd_t'(in_cmd);
            slot_addr_reg <= AW'(in_slot);
            slot_ok_reg   <= in_slot_ok;
            dir_reg       <= in_dir;
            point_reg     <= in_point;
            last_reg      <= AW'(eff_count - CW'(1));
        end
    end

    // Memory ports
    assign rd_en   = cmd.issue || (cmd.mem_op && (cmd_reg == dept_pkg::CMD_READ));
    assign rd_addr = cmd.issue ? addr_reg : slot_addr_reg;
    assign dir_we  = cmd.mem_op && (cmd_reg == dept_pkg::CMD_LOAD) && slot_ok_reg;
    assign pt_we   = v3_reg && better;

    always_comb begin
        sc_we    = 1'b0;
        sc_waddr = slot_addr_reg;
        sc_wdata = '0;
        priority if (cmd.clear_step) begin
            sc_we    = 1'b1;
            sc_waddr = addr_reg;
        end else if (pt_we) begin
            sc_we    = 1'b1;
            sc_waddr = addr3_reg;
            sc_wdata = {1'b1, sum3_reg};
        end else if (dir_we) begin
            // loading a direction empties the slot
            sc_we    = 1'b1;
            sc_waddr = slot_addr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (dir_we) begin
            dir_mem[slot_addr_reg] <= dir_reg;
        end
        if (sc_we) begin
            score_mem[sc_waddr] <= sc_wdata;
        end
        if (pt_we) begin
            point_mem[addr3_reg] <= point_reg;
        end
        if (rd_en) begin
            dir_rd_reg   <= dir_mem[rd_addr];
            score_rd_reg <= score_mem[rd_addr];
            point_rd_reg <= point_mem[rd_addr];
        end
    end

    // Sweep pipeline
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prod_next[k] = $signed(dir_rd_reg[k*DW +: DW])
                         * $signed(point_reg[k*COORD_BITS +: COORD_BITS]);
        end
        sum_next = SCORE_W'(prod_reg[0]) + SCORE_W'(prod_reg[1]) + SCORE_W'(prod_reg[2]);
    end

    assign better = !old3_reg[SCORE_W] || (sum3_reg > $signed(old3_reg[SCORE_W-1:0]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        addr1_reg <= addr_reg;
        addr2_reg <= addr1_reg;
        addr3_reg <= addr2_reg;
        for (int k = 0; k < 3; k++) begin
            prod_reg[k] <= prod_next[k];
        end
        old2_reg <= score_rd_reg;
        old3_reg <= old2_reg;
        sum3_reg <= sum_next;
    end

    // Result register
    assign read_hit = slot_ok_reg && score_rd_reg[SCORE_W];

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            unique case (cmd_reg)
                dept_pkg::CMD_ADD: begin
                    res_changed     <= changed_reg;
                    res_entry_valid <= 1'b0;
                    res_point       <= '0;
                end
                dept_pkg::CMD_READ: begin
                    res_changed     <= 1'b0;
                    res_entry_valid <= read_hit;
                    res_point       <= read_hit ? point_rd_reg : '0;
                end
                default: begin
                    res_changed     <= 1'b0;
                    res_entry_valid <= 1'b0;
                    res_point       <= '0;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/directional_extreme_point_tracker_top.sv =====
// ----------------------------------------------------------------------------
// directional_extreme_point_tracker_top: extreme point tracker, stream ports
// Keeps one unit direction per slot and the point lying furthest along it.
// ----------------------------------------------------------------------------
// One item is in work at a time and each gives exactly one result. An add
// item sweeps the slots in use (num_directions saturated to MAX_DIRECTIONS)
// through one shared multiply, sum and compare pipeline at one slot per
// cycle, then waits for the pipeline to drain before the result is loaded;
// with num_directions at zero it skips the sweep. Load and read items pass
// through one lookup step for the registered memory read, and unknown items
// go straight to the result. A stalled result holds the block for as long
// as m_tready stays low. After reset the score table is swept clear, one
// slot per cycle, before s_tready first rises; the configuration port is
// live throughout. Write num_directions only while the block is idle.
module directional_extreme_point_tracker_top #(
    parameter int MAX_DIRECTIONS = dept_pkg::MAX_DIRECTIONS_DEF,
    parameter int COORD_BITS     = dept_pkg::COORD_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // slot_index[6:0], dir_x, dir_y, dir_z, point_x, point_y, point_z, zero pad
    input  logic [((dept_pkg::SLOT_W + 3*dept_pkg::DIR_W + 3*COORD_BITS + 7) / 8) * 8 - 1:0]
                                              s_tdata,
    // cmd[1:0]
    input  logic [1:0]                        s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // changed[0], best_x, best_y, best_z, zero pad
    output logic [((1 + 3*COORD_BITS + 7) / 8) * 8 - 1:0]
                                              m_tdata,
    // entry_valid[0]
    output logic                              m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_we,
    input  logic [dept_pkg::NDIR_W-1:0]       cfg_wdata
);

    localparam int SW     = dept_pkg::SLOT_W;
    localparam int DW     = dept_pkg::DIR_W;
    localparam int OUT_W  = ((1 + 3*COORD_BITS + 7) / 8) * 8;

    dept_pkg::dp_cmd_t    dp_cmd;
    dept_pkg::dp_status_t dp_status;
    logic                 res_changed;
    logic                 res_entry_valid;
    logic [3*COORD_BITS-1:0] res_point;

    dept_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_cmd   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (dp_cmd),
        .status   (dp_status)
    );

    dept_datapath #(
        .MAX_DIRECTIONS (MAX_DIRECTIONS),
        .COORD_BITS     (COORD_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (dp_cmd),
        .status          (dp_status),
        .in_cmd          (s_tuser),
        .in_slot         (s_tdata[SW-1:0]),
        .in_dir          (s_tdata[SW +: 3*DW]),
        .in_point        (s_tdata[SW + 3*DW +: 3*COORD_BITS]),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .res_changed     (res_changed),
        .res_entry_valid (res_entry_valid),
        .res_point       (res_point)
    );

    assign m_tdata = OUT_W'({res_point, res_changed});
    assign m_tuser = res_entry_valid;

`ifndef SYNTHESIS
    // one item in work at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted back to back");

    // never overwrite a result that has not been transferred
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.finish |-> (!m_tvalid || m_tready))
        else $error("result register overwritten");

    // no item taken while the sweep pipeline still holds slots
    a_drain_first: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_status.pipe_busy |-> !s_tready)
        else $error("input ready with sweep in flight");

    // a result only follows completed work, never during the sweep
    a_finish_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.finish |-> !dp_status.pipe_busy && !dp_cmd.issue)
        else $error("result loaded during sweep");
`endif

endmodule
